// File: hdl/tss_pkg.sv
package tss_pkg;

  localparam int unsigned SUM_W  = 48;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SIZE_W = 9;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [SIZE_W-1:0] size_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Saturating 48-bit add.
  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic sum_t sext_word(word_t x);
    return {{(SUM_W-WORD_W){x[WORD_W-1]}}, x};
  endfunction

endpackage

// File: hdl/tss_in_if.sv
interface tss_in_if;
  logic             valid;
  logic             ready;
  tss_pkg::word_t   signal_yield;
  tss_pkg::word_t   background_yield;

  modport source (output valid, output signal_yield, output background_yield, input ready);
  modport sink   (input valid, input signal_yield, input background_yield, output ready);
endinterface

// File: hdl/tss_out_if.sv
interface tss_out_if;
  logic             valid;
  logic             ready;
  tss_pkg::word_t   significance;
  logic             negative_background;
  logic             last_of_frame;

  modport source (output valid, output significance, output negative_background,
                  output last_of_frame, input ready);
  modport sink   (input valid, input significance, input negative_background,
                  input last_of_frame, output ready);
endinterface

// File: hdl/tail_sum_significance_scan.sv
// Cut-scan significance S/sqrt(B) over a histogram of up to MAX_ROWS x MAX_COLUMNS
// bins, fed last row first and last column first within a row. Each accepted bin
// yields one result: the Q24.8 tail signal sum over the square root of the tail
// background sum, saturated, or zero when the tail background is not positive,
// with negative_background set when it is below zero. An item with a non-positive
// tail background goes from the line-store read straight to the output register;
// otherwise it passes the line-store read, the bit-pair square root loop, the
// one-bit-per-cycle restoring divider and the output register load. One item is in
// work at a time; the next is taken while the previous result waits in the output
// register. The line store needs no clearing pass: the last row ignores its read.
// Any register write restarts the frame at the last row and column.
module tail_sum_significance_scan #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  tss_in_if.sink             in_ch,
  tss_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SW = tss_pkg::SUM_W;

  // Configuration and frame position
  tss_pkg::size_t cols_r, cols_nxt, rows_r, rows_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  tss_pkg::sum_t  s_run_r, s_run_nxt, b_run_r, b_run_nxt;

  tss_pkg::state_t state_r, state_nxt;

  // Item in work
  tss_pkg::sum_t  s_acc_r, b_acc_r, s_tail_r, b_tail_r;
  logic [CW-1:0]  wcol_r;
  logic           top_r, last_r;
  tss_pkg::sum_t  s_mem_q, b_mem_q;

  // Column line store
  tss_pkg::sum_t  s_mem [MAX_COLUMNS];
  tss_pkg::sum_t  b_mem [MAX_COLUMNS];

  // Square root and divider
  logic [63:0]    n_r;
  logic [34:0]    srem_r;
  logic [31:0]    root_r;
  logic [63:0]    dvd_r, quo_r;
  logic [31:0]    drem_r;
  logic [5:0]     iter_r;

  // Output register
  logic           out_valid_r;
  tss_pkg::word_t out_sig_r;
  logic           out_neg_r, out_last_r;

  logic           cfg_wr, in_acc, row_end, frame_end, load_out;
  tss_pkg::size_t wr_size;
  tss_pkg::sum_t  s_acc, b_acc, s_tail, b_tail;
  logic [34:0]    srem_sh, strial;
  logic [32:0]    drem_sh;
  logic           s_neg;
  tss_pkg::word_t sig_sat;

  // Clamp a written size into one..maximum.
  function automatic tss_pkg::size_t clamp_size(tss_pkg::size_t v, int unsigned maxv);
    if (v == '0) return tss_pkg::size_t'(1);
    if (32'(v) > maxv) return tss_pkg::size_t'(maxv);
    return v;
  endfunction

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {23'd0, (cfg_paddr[2] == tss_pkg::REG_ROWS) ? rows_r : cols_r};
  assign wr_size    = cfg_pwdata[tss_pkg::SIZE_W-1:0];

  assign in_ch.ready = (state_r == tss_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign row_end   = (col_r == '0);
  assign frame_end = row_end && (row_r == '0);

  assign s_acc = tss_pkg::sat_add(s_run_r, tss_pkg::sext_word(in_ch.signal_yield));
  assign b_acc = tss_pkg::sat_add(b_run_r, tss_pkg::sext_word(in_ch.background_yield));

  // Add the row above unless this is the last (first scanned) row
  assign s_tail = top_r ? s_acc_r : tss_pkg::sat_add(s_acc_r, s_mem_q);
  assign b_tail = top_r ? b_acc_r : tss_pkg::sat_add(b_acc_r, b_mem_q);

  assign srem_sh = {srem_r[32:0], n_r[63:62]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign drem_sh = {drem_r, dvd_r[63]};

  assign s_neg = s_tail_r[SW-1];
  always_comb begin
    if (s_neg) begin
      sig_sat = (|quo_r[63:31]) ? {1'b1, 31'd0} : tss_pkg::word_t'(-quo_r[31:0]);
    end else begin
      sig_sat = (|quo_r[63:31]) ? {1'b0, {31{1'b1}}} : tss_pkg::word_t'(quo_r[31:0]);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tss_pkg::ST_IDLE: if (in_acc) state_nxt = tss_pkg::ST_READ;
      tss_pkg::ST_READ: state_nxt = (b_tail > 0) ? tss_pkg::ST_SQRT : tss_pkg::ST_DONE;
      tss_pkg::ST_SQRT: if (iter_r == 6'd31) state_nxt = tss_pkg::ST_DIV;
      tss_pkg::ST_DIV:  if (iter_r == 6'd63) state_nxt = tss_pkg::ST_DONE;
      tss_pkg::ST_DONE: if (load_out) state_nxt = tss_pkg::ST_IDLE;
      default:          state_nxt = tss_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load_out = (state_r == tss_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  end

  // Frame position and running sums
  always_comb begin
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    s_run_nxt = s_run_r;
    b_run_nxt = b_run_r;
    if (cfg_wr) begin
      if (cfg_paddr[2] == tss_pkg::REG_COLUMNS) cols_nxt = clamp_size(wr_size, MAX_COLUMNS);
      else                                      rows_nxt = clamp_size(wr_size, MAX_ROWS);
      col_nxt   = CW'(cols_nxt - 1'b1);
      row_nxt   = RW'(rows_nxt - 1'b1);
      s_run_nxt = '0;
      b_run_nxt = '0;
    end else if (in_acc) begin
      if (frame_end) begin
        col_nxt   = CW'(cols_r - 1'b1);
        row_nxt   = RW'(rows_r - 1'b1);
        s_run_nxt = '0;
        b_run_nxt = '0;
      end else if (row_end) begin
        col_nxt   = CW'(cols_r - 1'b1);
        row_nxt   = row_r - 1'b1;
        s_run_nxt = '0;
        b_run_nxt = '0;
      end else begin
        col_nxt   = col_r - 1'b1;
        s_run_nxt = s_acc;
        b_run_nxt = b_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tss_pkg::ST_IDLE;
      cols_r      <= clamp_size(tss_pkg::size_t'(256), MAX_COLUMNS);
      rows_r      <= tss_pkg::size_t'(1);
      col_r       <= CW'(clamp_size(tss_pkg::size_t'(256), MAX_COLUMNS) - 1'b1);
      row_r       <= '0;
      s_run_r     <= '0;
      b_run_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s_run_r <= s_run_nxt;
      b_run_r <= b_run_nxt;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Line store: read at accept, write back the tail sums in the next cycle (ST_READ)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_mem_q <= s_mem[col_r];
      b_mem_q <= b_mem[col_r];
    end
    if (state_r == tss_pkg::ST_READ) begin
      s_mem[wcol_r] <= s_tail;
      b_mem[wcol_r] <= b_tail;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      tss_pkg::ST_IDLE: begin
        if (in_acc) begin
          s_acc_r <= s_acc;
          b_acc_r <= b_acc;
          wcol_r  <= col_r;
          top_r   <= (32'(row_r) + 1 >= 32'(rows_r));
          last_r  <= frame_end;
        end
      end
      tss_pkg::ST_READ: begin
        s_tail_r <= s_tail;
        b_tail_r <= b_tail;
        n_r      <= {b_tail, 16'd0};
        srem_r   <= '0;
        root_r   <= '0;
        quo_r    <= '0;
        iter_r   <= '0;
      end
      tss_pkg::ST_SQRT: begin
        n_r <= {n_r[61:0], 2'b00};
        if (srem_sh >= strial) begin
          srem_r <= srem_sh - strial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= srem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
        iter_r <= (iter_r == 6'd31) ? 6'd0 : iter_r + 1'b1;
        // Load the dividend |S| * 2^16 for the divider
        dvd_r  <= {(s_tail_r[SW-1] ? -s_tail_r : s_tail_r), 16'd0};
        drem_r <= '0;
      end
      tss_pkg::ST_DIV: begin
        dvd_r <= {dvd_r[62:0], 1'b0};
        if (drem_sh >= {1'b0, root_r}) begin
          drem_r <= 32'(drem_sh - {1'b0, root_r});
          quo_r  <= {quo_r[62:0], 1'b1};
        end else begin
          drem_r <= drem_sh[31:0];
          quo_r  <= {quo_r[62:0], 1'b0};
        end
        iter_r <= iter_r + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_sig_r  <= (b_tail_r > 0) ? sig_sat : '0;
      out_neg_r  <= b_tail_r[SW-1];
      out_last_r <= last_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.significance        = out_sig_r;
  assign out_ch.negative_background = out_neg_r;
  assign out_ch.last_of_frame       = out_last_r;

`ifndef NO_ASSERTIONS
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.negative_background |-> out_ch.significance == '0)
    else $error("negative background with nonzero significance");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(cols_r))
    else $error("column position beyond columns in use");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tss_pkg::ST_DONE && !load_out |=> state_r == tss_pkg::ST_DONE && out_ch.valid)
    else $error("finished result dropped while output stalled");
`endif

endmodule
